// File: sv/lfows_pkg.sv
`timescale 1ns / 1ps
// lfows_pkg: shared types, constants and the quarter-wave sine table
// for the lfo waveform shaper; no dependencies
package lfows_pkg;

  localparam int PHASE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 8;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int LEVEL_BITS      = 16;

  localparam int TABLE_STEPS  = 1 << SINE_TABLE_BITS;
  localparam int SINE_ENTRIES = TABLE_STEPS + 1;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int SINE_W       = 31;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam int WAVE_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 3;

  localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_ISAW   = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SLOPED = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNI  = 1'b1;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_sel;
    logic              unipolar;
  } cfg_t;

  typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_tab_t;

  // 2n(2n+1) for the taylor terms
  localparam logic [63:0] TAYLOR_DIV [0:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  function automatic logic [SINE_W-1:0] taylor_sin_q30(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (HALF_PI_Q30 * 64'(k) + 64'(TABLE_STEPS / 2)) >> SINE_TABLE_BITS;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    if (acc > signed'(ONE_Q30)) begin
      acc = signed'(ONE_Q30);
    end
    return acc[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      tab[k] = taylor_sin_q30(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

// File: sv/lfows_if.sv
`timescale 1ns / 1ps
// lfows_phase_if and lfows_level_if: valid/ready channels for phase items
// and level items; depends on lfows_pkg
interface lfows_phase_if;
  import lfows_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase;
  modport source(output valid, output phase, input ready);
  modport sink(input valid, input phase, output ready);
endinterface

interface lfows_level_if;
  import lfows_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] level;
  modport source(output valid, output level, input ready);
  modport sink(input valid, input level, output ready);
endinterface

// File: sv/lfo_waveform_shaper.sv
`timescale 1ns / 1ps
// lfo_waveform_shaper: phase in, waveform level out, one item per cycle while the output is not stalled
// path: input register, then result register; the level is computed combinationally between them and registered
// throughput: one item per clock when the output is ready, set by the single registered pass; on a stalled output
// the result register holds and the input register still fills an empty slot
// reset (rst_n low, synchronous): pipeline emptied, wave_select = sine, bipolar range
// depends on lfows_pkg, lfows_if and lfows_shape
module lfo_waveform_shaper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfows_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfows_pkg::CFG_W-1:0]     cfg_data,
  lfows_phase_if.sink                     in_if,
  lfows_level_if.source                   out_if
);
  import lfows_pkg::*;

  cfg_t                         cfg_r;
  logic                         s1_valid_r;
  logic [PHASE_BITS-1:0]        s1_phase_r;
  logic                         s2_valid_r;
  logic signed [LEVEL_BITS-1:0] s2_level_r;
  logic signed [LEVEL_BITS-1:0] level_nxt;
  logic                         s2_load;
  logic                         s1_load;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_sel <= WAVE_SINE;
      cfg_r.unipolar <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WAVE: cfg_r.wave_sel <= cfg_data[WAVE_W-1:0];
        CFG_IDX_UNI:  cfg_r.unipolar <= cfg_data[0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  assign s2_load     = !s2_valid_r || out_if.ready;
  assign s1_load     = !s1_valid_r || s2_load;
  assign in_if.ready = s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_if.valid) begin
      s1_phase_r <= in_if.phase;
    end
    if (s2_load && s1_valid_r) begin
      s2_level_r <= level_nxt;
    end
  end

  lfows_shape u_shape (
    .phase (s1_phase_r),
    .cfg   (cfg_r),
    .level (level_nxt)
  );

  assign out_if.valid = s2_valid_r;
  assign out_if.level = s2_level_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !s1_valid_r && !s2_valid_r)
    else $error("pipeline not empty after reset");

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> s1_valid_r)
    else $error("accepted item lost at input stage");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> s2_valid_r)
    else $error("item lost between stages");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_phase_r))
    else $error("stalled input stage changed");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> s2_level_r >= -16'sd16384 && s2_level_r <= 16'sd16384)
    else $error("level out of range");

endmodule

// File: sv/lfows_shape.sv
`timescale 1ns / 1ps
// lfows_shape: combinational waveform value for one phase sample
// depends on lfows_pkg (sine table, wave codes, cfg_t)
module lfows_shape (
  input  logic [lfows_pkg::PHASE_BITS-1:0]        phase,
  input  lfows_pkg::cfg_t                         cfg,
  output logic signed [lfows_pkg::LEVEL_BITS-1:0] level
);
  import lfows_pkg::*;

  localparam int VW = 32;
  localparam logic signed [VW-1:0] Q  = VW'(1 << PHASE_BITS);
  localparam logic signed [VW-1:0] U  = VW'(1 << (PHASE_BITS + 1));
  localparam logic signed [VW-1:0] UH = VW'(1 << PHASE_BITS);
  localparam int RSH = PHASE_BITS + 1 - OUT_FRAC_BITS;
  localparam logic signed [VW-1:0] RND = VW'(1 << (RSH - 1));
  localparam int QW  = PHASE_BITS - 2;
  localparam int FW  = QW - SINE_TABLE_BITS;
  localparam int SW  = 34;
  localparam logic signed [SW-1:0] RND_BI  = SW'(64'd1 << (30 - OUT_FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RND_UNI = SW'(64'd1 << (31 - OUT_FRAC_BITS - 1));
  localparam logic signed [SW-1:0] ONE_S   = SW'(ONE_Q30);

  logic signed [VW-1:0]         p;
  logic signed [VW-1:0]         v;
  logic signed [VW-1:0]         v_rnd;
  logic signed [VW-1:0]         p100;
  logic                         uni;
  logic [1:0]                   quad;
  logic [QW:0]                  m;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [SINE_IDX_W-1:0]        idx_lo;
  logic [SINE_IDX_W-1:0]        idx_hi;
  logic [FW-1:0]                frac;
  logic [SINE_W-1:0]            lo;
  logic [SINE_W-1:0]            hi;
  logic [SINE_W+FW-1:0]         prod;
  logic [SINE_W-1:0]            mag;
  logic signed [SW-1:0]         s;
  logic signed [SW-1:0]         t_bi;
  logic signed [SW-1:0]         t_uni;
  logic signed [LEVEL_BITS-1:0] lvl_lin;
  logic signed [LEVEL_BITS-1:0] lvl_sine;
  logic                         is_sine;

  assign p    = signed'(VW'(phase));
  assign uni  = cfg.unipolar;
  assign p100 = p * VW'(100);

  always_comb begin
    v = '0;
    case (cfg.wave_sel)
      WAVE_TRI: begin
        if (4 * p < Q) begin
          v = uni ? UH + 4 * p : 8 * p;
        end else if (4 * p < 3 * Q) begin
          v = uni ? U - 4 * p + Q : U - 8 * p + 2 * Q;
        end else begin
          v = uni ? 4 * p - 3 * Q : 8 * p - 6 * Q - U;
        end
      end
      WAVE_SQUARE: begin
        v = (2 * p < Q) ? U : (uni ? VW'(0) : -U);
      end
      WAVE_SAW: begin
        if (2 * p < Q) begin
          v = uni ? UH + 2 * p : 4 * p;
        end else begin
          v = uni ? 2 * p - UH : 4 * p - 2 * U;
        end
      end
      WAVE_ISAW: begin
        if (2 * p < Q) begin
          v = uni ? UH - 2 * p : -(4 * p);
        end else begin
          v = uni ? 3 * UH - 2 * p : 2 * U - 4 * p;
        end
      end
      WAVE_SLOPED: begin
        if (p100 < 48 * Q) begin
          v = U;
        end else if (2 * p < Q) begin
          v = U - (p100 - 48 * Q);
        end else if (p100 < 98 * Q) begin
          v = '0;
        end else begin
          v = p100 - 98 * Q;
        end
        if (!uni) begin
          v = 2 * v - U;
        end
      end
      default: v = '0;
    endcase
  end

  // half-up rounding to the output grid
  assign v_rnd   = (v + RND) >>> RSH;
  assign lvl_lin = v_rnd[LEVEL_BITS-1:0];

  // quarter-wave sine with mirrored phase and linear interpolation
  assign quad   = phase[PHASE_BITS-1:PHASE_BITS-2];
  assign m      = quad[0] ? ((QW+1)'(1) << QW) - {1'b0, phase[QW-1:0]}
                          : {1'b0, phase[QW-1:0]};
  assign idx    = m[QW-1:FW];
  assign frac   = m[FW-1:0];
  assign idx_lo = m[QW] ? SINE_IDX_W'(TABLE_STEPS) : {1'b0, idx};
  assign idx_hi = m[QW] ? SINE_IDX_W'(TABLE_STEPS) : {1'b0, idx} + SINE_IDX_W'(1);
  assign lo     = SINE_TABLE[idx_lo];
  assign hi     = SINE_TABLE[idx_hi];
  assign prod   = (SINE_W+FW)'(hi - lo) * (SINE_W+FW)'(frac);

  always_comb begin
    if (m[QW] || frac == '0 || hi <= lo) begin
      mag = lo;
    end else begin
      mag = lo + prod[SINE_W+FW-1:FW];
    end
  end

  assign s        = quad[1] ? -signed'(SW'(mag)) : signed'(SW'(mag));
  assign t_bi     = (s + RND_BI) >>> (30 - OUT_FRAC_BITS);
  assign t_uni    = (ONE_S + s + RND_UNI) >>> (31 - OUT_FRAC_BITS);
  assign lvl_sine = uni ? t_uni[LEVEL_BITS-1:0] : t_bi[LEVEL_BITS-1:0];

  assign is_sine = (cfg.wave_sel != WAVE_TRI) && (cfg.wave_sel != WAVE_SQUARE) &&
                   (cfg.wave_sel != WAVE_SAW) && (cfg.wave_sel != WAVE_ISAW) &&
                   (cfg.wave_sel != WAVE_SLOPED);
  assign level   = is_sine ? lvl_sine : lvl_lin;

endmodule
